// File: design/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

  // Default sizes of the arena and the record store
  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned ARENA_BITS_DEF   = 16;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned MIN_SPLIT_DEF    = 16;

  // Width that holds request + header + minimum split without overflow
  localparam int unsigned CMP_W = 34;

  // APB register map
  localparam int unsigned APB_AW    = 3;
  localparam logic        REG_BASE  = 1'b0;
  localparam logic        REG_BYTES = 1'b1;

  localparam logic [15:0] BYTES_RST = 16'hFFFF;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_NULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EXAM,
    S_GRAB,
    S_GRAB2,
    S_SPLIT_W,
    S_SPLIT_C,
    S_FIX_RD,
    S_FIX_WR,
    S_F_NX,
    S_F_NXCHK,
    S_F_WC,
    S_F_PVCHK,
    S_F_WP,
    S_DONE
  } st_e;

endpackage
`default_nettype wire

// File: design/ffba_ram.sv
`default_nettype none
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: design/first_fit_block_allocator.sv
`default_nettype none
// Sequence: a free of a null address goes from idle straight to the final state; otherwise
//   the chain is walked one record a cycle from the record memory, then the updates run.
// Items: one item at a time; the final state waits while an earlier result is still held
//   by a stalled sink.
// Reset: asynchronous, active low. After reset, and after each write of arena_bytes, the
//   chain is rebuilt as one free block in record zero.
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned ARENA_BITS   = ffba_pkg::ARENA_BITS_DEF,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MIN_SPLIT    = ffba_pkg::MIN_SPLIT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input items
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  input  wire logic [47:0]                  s_tdata,  // [15:0] request_bytes, [47:16] payload_address
  input  wire logic [0:0]                   s_tuser,  // [0] opcode
  // result items
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  output logic      [31:0]                  m_tdata,  // [31:0] granted_address
  output logic      [1:0]                   m_tuser,  // [1:0] status
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ffba_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned PW = IW + 1;
  localparam logic [PW-1:0] NONE = PW'(MAX_BLOCKS);
  localparam logic [ARENA_BITS-1:0] HDR_A = ARENA_BITS'(HEADER_BYTES);
  localparam int unsigned CW = ffba_pkg::CMP_W;

  // One record of the chain, as stored in the record memory
  typedef struct packed {
    logic [ARENA_BITS-1:0] start;
    logic [ARENA_BITS-1:0] pay;
    logic                  free;
    logic [PW-1:0]         nxt;
    logic [PW-1:0]         prv;
  } rec_t;

  localparam int unsigned RW = $bits(rec_t);

  ffba_pkg::st_e state_q, state_d, ret_q, ret_d;

  logic        op_q, op_d;
  logic [15:0] req_q, req_d;
  logic [31:0] addr_q, addr_d;
  logic [IW-1:0] cur_q, cur_d, head_q, head_d, nr_q, nr_d, pv_q, pv_d;
  logic [IW-1:0] fix_idx_q, fix_idx_d, fix_val_q, fix_val_d;
  logic [PW-1:0] steps_q, steps_d, sp_q, sp_d, fresh_q, fresh_d;
  rec_t        c_q, c_d, p_q, p_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [1:0]  res_st_q, res_st_d;
  logic        ov_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_st_q;
  logic [31:0] base_q;
  logic [15:0] bytes_q;
  logic        load_out;

  // memory ports
  logic          rec_we, rec_re;
  logic [IW-1:0] rec_waddr, rec_raddr;
  rec_t          rec_wdata, rd_rec;
  logic [RW-1:0] rec_rdata;
  logic          stk_we, stk_re;
  logic [IW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  // -------------------------------------------------------------------------
  // Configuration port
  // -------------------------------------------------------------------------
  logic cfg_wr, cfg_bytes_wr;
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign cfg_bytes_wr = cfg_wr && (paddr[2] == ffba_pkg::REG_BYTES);
  assign prdata       = (paddr[2] == ffba_pkg::REG_BYTES) ? {16'h0000, bytes_q} : base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      bytes_q <= ffba_pkg::BYTES_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == ffba_pkg::REG_BASE) begin
        base_q <= pwdata;
      end else begin
        bytes_q <= pwdata[15:0];
      end
    end
  end

  // -------------------------------------------------------------------------
  // Storage: record memory and stack of released record numbers
  // -------------------------------------------------------------------------
  ffba_ram #(.WIDTH(RW), .DEPTH(MAX_BLOCKS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );
  assign rd_rec = rec_t'(rec_rdata);

  ffba_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // -------------------------------------------------------------------------
  // Decisions on the record just read
  // -------------------------------------------------------------------------
  logic [CW-1:0]         whole;
  logic                  fit_whole, fit_split, free_hit, walk_end, nx_merge, pv_merge;
  logic [ARENA_BITS-1:0] pay0, rd_end, c_end;
  logic [31:0]           rd_paddr;

  assign whole     = CW'(req_q) + CW'(HEADER_BYTES);
  assign fit_whole = rd_rec.free && (CW'(rd_rec.pay) >= whole);
  assign fit_split = fit_whole && (CW'(rd_rec.pay) >= whole + CW'(MIN_SPLIT));
  assign rd_paddr  = base_q + 32'(rd_rec.start) + 32'(HEADER_BYTES);
  assign free_hit  = (rd_paddr == addr_q);
  assign walk_end  = (steps_q + 1'b1 == PW'(MAX_BLOCKS)) || (rd_rec.nxt == NONE);
  assign rd_end    = rd_rec.start + HDR_A + rd_rec.pay;
  assign c_end     = c_q.start + HDR_A + c_q.pay;
  assign nx_merge  = rd_rec.free && (c_end == rd_rec.start);
  assign pv_merge  = rd_rec.free && (rd_end == c_q.start);
  assign pay0      = (bytes_q >= 16'(HEADER_BYTES)) ?
                     ARENA_BITS'(bytes_q - 16'(HEADER_BYTES)) : '0;

  // -------------------------------------------------------------------------
  // Sequencer: next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    if (cfg_bytes_wr) begin
      state_d = ffba_pkg::S_INIT;
    end else begin
      unique case (state_q)
        ffba_pkg::S_INIT:  state_d = ffba_pkg::S_IDLE;
        ffba_pkg::S_IDLE: begin
          if (s_tvalid) begin
            state_d = (s_tuser[0] == ffba_pkg::OP_FREE && s_tdata[47:16] == '0) ?
                      ffba_pkg::S_DONE : ffba_pkg::S_EXAM;
          end
        end
        ffba_pkg::S_EXAM: begin
          if (op_q == ffba_pkg::OP_ALLOC) begin
            if (fit_split)      state_d = ffba_pkg::S_GRAB;
            else if (fit_whole) state_d = ffba_pkg::S_DONE;
            else if (walk_end)  state_d = ffba_pkg::S_DONE;
          end else begin
            if (free_hit)       state_d = ffba_pkg::S_F_NX;
            else if (walk_end)  state_d = ffba_pkg::S_DONE;
          end
        end
        ffba_pkg::S_GRAB: begin
          if (sp_q != '0)                      state_d = ffba_pkg::S_GRAB2;
          else if (fresh_q != PW'(MAX_BLOCKS)) state_d = ffba_pkg::S_SPLIT_W;
          else                                 state_d = ffba_pkg::S_DONE;
        end
        ffba_pkg::S_GRAB2:   state_d = ffba_pkg::S_SPLIT_W;
        ffba_pkg::S_SPLIT_W: state_d = (c_q.nxt != NONE) ? ffba_pkg::S_FIX_RD
                                                         : ffba_pkg::S_SPLIT_C;
        ffba_pkg::S_SPLIT_C: state_d = ffba_pkg::S_DONE;
        ffba_pkg::S_FIX_RD:  state_d = ffba_pkg::S_FIX_WR;
        ffba_pkg::S_FIX_WR:  state_d = ret_q;
        ffba_pkg::S_F_NX:    state_d = (c_q.nxt != NONE) ? ffba_pkg::S_F_NXCHK
                                                         : ffba_pkg::S_F_WC;
        ffba_pkg::S_F_NXCHK: state_d = (nx_merge && rd_rec.nxt != NONE) ? ffba_pkg::S_FIX_RD
                                                                        : ffba_pkg::S_F_WC;
        ffba_pkg::S_F_WC:    state_d = (c_q.prv != NONE) ? ffba_pkg::S_F_PVCHK
                                                         : ffba_pkg::S_DONE;
        ffba_pkg::S_F_PVCHK: begin
          if (!pv_merge)              state_d = ffba_pkg::S_DONE;
          else if (c_q.nxt != NONE)   state_d = ffba_pkg::S_FIX_RD;
          else                        state_d = ffba_pkg::S_F_WP;
        end
        ffba_pkg::S_F_WP:    state_d = ffba_pkg::S_DONE;
        ffba_pkg::S_DONE:    state_d = (!ov_q || m_tready) ? ffba_pkg::S_IDLE
                                                           : ffba_pkg::S_DONE;
        default:             state_d = ffba_pkg::S_INIT;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: memory accesses and datapath updates
  // -------------------------------------------------------------------------
  always_comb begin
    op_d       = op_q;
    req_d      = req_q;
    addr_d     = addr_q;
    cur_d      = cur_q;
    head_d     = head_q;
    nr_d       = nr_q;
    pv_d       = pv_q;
    fix_idx_d  = fix_idx_q;
    fix_val_d  = fix_val_q;
    ret_d      = ret_q;
    steps_d    = steps_q;
    sp_d       = sp_q;
    fresh_d    = fresh_q;
    c_d        = c_q;
    p_d        = p_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    rec_we     = 1'b0;
    rec_waddr  = '0;
    rec_wdata  = '0;
    rec_re     = 1'b0;
    rec_raddr  = '0;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_re     = 1'b0;
    stk_raddr  = '0;
    load_out   = 1'b0;

    unique case (state_q)
      ffba_pkg::S_INIT: begin
        // rebuild the chain as one free block in record zero
        rec_we    = 1'b1;
        rec_wdata = '{start: '0, pay: pay0, free: 1'b1, nxt: NONE, prv: NONE};
        head_d    = '0;
        sp_d      = '0;
        fresh_d   = PW'(1);
      end
      ffba_pkg::S_IDLE: begin
        if (s_tvalid) begin
          op_d       = s_tuser[0];
          req_d      = s_tdata[15:0];
          addr_d     = s_tdata[47:16];
          steps_d    = '0;
          cur_d      = head_q;
          res_addr_d = '0;
          res_st_d   = ffba_pkg::ST_NULL;
          rec_re     = 1'b1;
          rec_raddr  = head_q;
        end
      end
      ffba_pkg::S_EXAM: begin
        c_d = rd_rec;
        if (op_q == ffba_pkg::OP_ALLOC && fit_whole) begin
          res_addr_d = rd_paddr;
          res_st_d   = ffba_pkg::ST_OK;
          if (!fit_split) begin
            rec_we         = 1'b1;
            rec_waddr      = cur_q;
            rec_wdata      = rd_rec;
            rec_wdata.free = 1'b0;
          end
        end else if (op_q == ffba_pkg::OP_FREE && free_hit) begin
          c_d.free   = 1'b1;
          res_addr_d = '0;
          res_st_d   = ffba_pkg::ST_OK;
        end else if (walk_end) begin
          res_addr_d = '0;
          res_st_d   = (op_q == ffba_pkg::OP_ALLOC) ? ffba_pkg::ST_NOSPACE
                                                    : ffba_pkg::ST_UNKNOWN;
        end else begin
          // advance along the chain, reading the next record at once
          cur_d     = rd_rec.nxt[IW-1:0];
          steps_d   = steps_q + 1'b1;
          rec_re    = 1'b1;
          rec_raddr = rd_rec.nxt[IW-1:0];
        end
      end
      ffba_pkg::S_GRAB: begin
        if (sp_q != '0) begin
          stk_re    = 1'b1;
          stk_raddr = IW'(sp_q - 1'b1);
          sp_d      = sp_q - 1'b1;
        end else if (fresh_q != PW'(MAX_BLOCKS)) begin
          nr_d    = fresh_q[IW-1:0];
          fresh_d = fresh_q + 1'b1;
        end else begin
          // no spare record: hand the block out whole
          rec_we         = 1'b1;
          rec_waddr      = cur_q;
          rec_wdata      = c_q;
          rec_wdata.free = 1'b0;
        end
      end
      ffba_pkg::S_GRAB2: begin
        nr_d = stk_rdata;
      end
      ffba_pkg::S_SPLIT_W: begin
        rec_we    = 1'b1;
        rec_waddr = nr_q;
        rec_wdata = '{start: ARENA_BITS'(CW'(c_q.start) + whole),
                      pay:   ARENA_BITS'(CW'(c_q.pay) - whole),
                      free:  1'b1,
                      nxt:   c_q.nxt,
                      prv:   PW'(cur_q)};
        fix_idx_d = c_q.nxt[IW-1:0];
        fix_val_d = nr_q;
        ret_d     = ffba_pkg::S_SPLIT_C;
      end
      ffba_pkg::S_SPLIT_C: begin
        rec_we    = 1'b1;
        rec_waddr = cur_q;
        rec_wdata = '{start: c_q.start, pay: ARENA_BITS'(req_q), free: 1'b0,
                      nxt: PW'(nr_q), prv: c_q.prv};
      end
      ffba_pkg::S_FIX_RD: begin
        rec_re    = 1'b1;
        rec_raddr = fix_idx_q;
      end
      ffba_pkg::S_FIX_WR: begin
        rec_we        = 1'b1;
        rec_waddr     = fix_idx_q;
        rec_wdata     = rd_rec;
        rec_wdata.prv = PW'(fix_val_q);
      end
      ffba_pkg::S_F_NX: begin
        rec_re    = 1'b1;
        rec_raddr = c_q.nxt[IW-1:0];
      end
      ffba_pkg::S_F_NXCHK: begin
        if (nx_merge) begin
          // fold the successor into this block and release its record
          c_d.pay   = c_q.pay + HDR_A + rd_rec.pay;
          c_d.nxt   = rd_rec.nxt;
          stk_we    = 1'b1;
          stk_waddr = sp_q[IW-1:0];
          stk_wdata = c_q.nxt[IW-1:0];
          sp_d      = sp_q + 1'b1;
          if (head_q == c_q.nxt[IW-1:0]) begin
            head_d = cur_q;
          end
          fix_idx_d = rd_rec.nxt[IW-1:0];
          fix_val_d = cur_q;
          ret_d     = ffba_pkg::S_F_WC;
        end
      end
      ffba_pkg::S_F_WC: begin
        rec_we    = 1'b1;
        rec_waddr = cur_q;
        rec_wdata = c_q;
        if (c_q.prv != NONE) begin
          rec_re    = 1'b1;
          rec_raddr = c_q.prv[IW-1:0];
        end
      end
      ffba_pkg::S_F_PVCHK: begin
        if (pv_merge) begin
          // fold this block into its predecessor and release its record
          p_d       = rd_rec;
          p_d.pay   = rd_rec.pay + HDR_A + c_q.pay;
          p_d.nxt   = c_q.nxt;
          pv_d      = c_q.prv[IW-1:0];
          stk_we    = 1'b1;
          stk_waddr = sp_q[IW-1:0];
          stk_wdata = cur_q;
          sp_d      = sp_q + 1'b1;
          if (head_q == cur_q) begin
            head_d = c_q.prv[IW-1:0];
          end
          fix_idx_d = c_q.nxt[IW-1:0];
          fix_val_d = c_q.prv[IW-1:0];
          ret_d     = ffba_pkg::S_F_WP;
        end
      end
      ffba_pkg::S_F_WP: begin
        rec_we    = 1'b1;
        rec_waddr = pv_q;
        rec_wdata = p_q;
      end
      ffba_pkg::S_DONE: begin
        load_out = !ov_q || m_tready;
      end
      default: begin
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // Registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_INIT;
      ret_q   <= ffba_pkg::S_DONE;
      head_q  <= '0;
      sp_q    <= '0;
      fresh_q <= PW'(1);
      steps_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      head_q  <= head_d;
      sp_q    <= sp_d;
      fresh_q <= fresh_d;
      steps_q <= steps_d;
      if (load_out) begin
        ov_q <= 1'b1;
      end else if (m_tready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    req_q      <= req_d;
    addr_q     <= addr_d;
    cur_q      <= cur_d;
    nr_q       <= nr_d;
    pv_q       <= pv_d;
    fix_idx_q  <= fix_idx_d;
    fix_val_q  <= fix_val_d;
    c_q        <= c_d;
    p_q        <= p_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    if (load_out) begin
      out_addr_q <= res_addr_q;
      out_st_q   <= res_st_q;
    end
  end

  // hold a finished result in the output register while the next item runs
  assign s_tready = (state_q == ffba_pkg::S_IDLE);
  assign m_tvalid = ov_q;
  assign m_tdata  = out_addr_q;
  assign m_tuser  = out_st_q;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q < fresh_q) else $error("released records exceed records handed out");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffba_pkg::S_EXAM) |-> (steps_q < PW'(MAX_BLOCKS)))
    else $error("chain walk ran past the record count");

  a_null_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffba_pkg::S_DONE && res_st_q == ffba_pkg::ST_NULL) |->
    (op_q == ffba_pkg::OP_FREE)) else $error("null status on an allocate");

  a_accept_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |=>
    (state_q == ffba_pkg::S_EXAM || state_q == ffba_pkg::S_DONE ||
     state_q == ffba_pkg::S_INIT)) else $error("accepted item did not start");

endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

// One expected result of the allocator: granted payload address and status.
typedef struct packed {
  logic [31:0] granted;
  logic [1:0]  status;
} alloc_result_t;

// Tracks the arena's block chain and queues the result each accepted item must produce.
class alloc_scoreboard;
  localparam int NREC = 64;
  localparam int HDR = 32;
  localparam int MINSPLIT = 16;

  logic [31:0]   base;
  logic [15:0]   size;
  logic [15:0]   rec_start[NREC];
  logic [15:0]   rec_pay[NREC];
  bit            rec_free[NREC];
  int            rec_next[NREC];
  int            rec_prev[NREC];
  bit            in_use[NREC];
  int            head;
  alloc_result_t due[$];
  logic [31:0]   live[$];
  logic [31:0]   retired[$];
  int            errors;

  function void rebuild();
    for (int i = 0; i < NREC; i++) begin
      rec_start[i] = '0; rec_pay[i] = '0; rec_free[i] = 0;
      rec_next[i] = 0; rec_prev[i] = 0; in_use[i] = 0;
    end
    head = 0;
    in_use[0] = 1;
    rec_free[0] = 1;
    rec_next[0] = NREC;
    rec_prev[0] = NREC;
    rec_pay[0] = (size >= HDR) ? size - 16'(HDR) : 16'd0;
    live.delete();
    retired.delete();
  endfunction

  function void reset_state();
    base = '0;
    size = 16'hFFFF;
    errors = 0;
    rebuild();
  endfunction

  function void write_reg(logic idx, logic [31:0] value);
    if (idx == ffba_pkg::REG_BASE) begin
      base = value;
    end else begin
      size = value[15:0];
      rebuild();
    end
  endfunction

  function logic [31:0] payload_of(int r);
    return base + 32'(rec_start[r]) + 32'(HDR);
  endfunction

  // Fold block b into its lower neighbor a.
  function void absorb(int a, int b);
    int nb;
    nb = rec_next[b];
    rec_pay[a] = rec_pay[a] + 16'(HDR) + rec_pay[b];
    rec_next[a] = nb;
    if (nb < NREC) rec_prev[nb] = a;
    if (head == b) head = a;
    in_use[b] = 0; rec_start[b] = '0; rec_pay[b] = '0;
    rec_free[b] = 0; rec_next[b] = 0; rec_prev[b] = 0;
  endfunction

  function alloc_result_t first_fit(logic [15:0] req);
    alloc_result_t res;
    int cur, nr, nx, whole, pay;
    cur = head;
    res.granted = '0;
    res.status = ffba_pkg::ST_NOSPACE;
    for (int steps = 0; steps < NREC && cur < NREC; steps++) begin
      pay = rec_pay[cur];
      whole = int'(req) + HDR;
      if (rec_free[cur] && pay >= whole) begin
        if (pay >= whole + MINSPLIT) begin
          nr = NREC;
          for (int i = 0; i < NREC; i++)
            if (!in_use[i] && nr == NREC) nr = i;
          // Pool exhausted: hand out the whole block instead.
          if (nr < NREC) begin
            in_use[nr] = 1;
            nx = rec_next[cur];
            rec_start[nr] = rec_start[cur] + 16'(whole);
            rec_pay[nr] = 16'(pay - whole);
            rec_free[nr] = 1;
            rec_next[nr] = nx;
            rec_prev[nr] = cur;
            if (nx < NREC) rec_prev[nx] = nr;
            rec_pay[cur] = req;
            rec_next[cur] = nr;
          end
        end
        rec_free[cur] = 0;
        res.granted = payload_of(cur);
        res.status = ffba_pkg::ST_OK;
        return res;
      end
      cur = rec_next[cur];
    end
    return res;
  endfunction

  function logic [1:0] release_block(logic [31:0] addr);
    int cur, nx, pv, found;
    logic [15:0] block_end;
    if (addr == '0) return ffba_pkg::ST_NULL;
    cur = head;
    found = 0;
    for (int steps = 0; steps < NREC && cur < NREC; steps++) begin
      if (payload_of(cur) == addr) begin
        found = 1;
        break;
      end
      cur = rec_next[cur];
    end
    if (!found) return ffba_pkg::ST_UNKNOWN;
    rec_free[cur] = 1;
    nx = rec_next[cur];
    block_end = rec_start[cur] + 16'(HDR) + rec_pay[cur];
    if (nx < NREC && rec_free[nx] && block_end == rec_start[nx]) absorb(cur, nx);
    pv = rec_prev[cur];
    if (pv < NREC) begin
      block_end = rec_start[pv] + 16'(HDR) + rec_pay[pv];
      if (rec_free[pv] && block_end == rec_start[cur]) absorb(pv, cur);
    end
    return ffba_pkg::ST_OK;
  endfunction

  // Note an accepted input item and queue its expected result.
  function void note_item(logic op, logic [15:0] req, logic [31:0] addr);
    alloc_result_t res;
    if (op == ffba_pkg::OP_ALLOC) begin
      res = first_fit(req);
      if (res.status == ffba_pkg::ST_OK) live.push_back(res.granted);
    end else begin
      res.granted = '0;
      res.status = release_block(addr);
      if (res.status == ffba_pkg::ST_OK) begin
        foreach (live[i])
          if (live[i] == addr) begin
            live.delete(i);
            break;
          end
        retired.push_back(addr);
        if (retired.size() > 16) void'(retired.pop_front());
      end
    end
    due.push_back(res);
  endfunction

  // Compare one accepted result item with the oldest expectation.
  function void check_result(logic [31:0] granted, logic [1:0] status);
    alloc_result_t exp_res;
    if (due.size() == 0) begin
      $error("result with nothing expected: granted_address %h status %0d", granted, status);
      errors++;
      return;
    end
    exp_res = due.pop_front();
    if (granted !== exp_res.granted) begin
      $error("granted_address: expected %h, got %h", exp_res.granted, granted);
      errors++;
    end
    if (status !== exp_res.status) begin
      $error("status: expected %0d, got %0d", exp_res.status, status);
      errors++;
    end
  endfunction
endclass

module tb;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // [15:0] request_bytes, [47:16] payload_address
  logic [0:0]  s_tuser = '0;  // [0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // [31:0] granted_address
  logic [1:0]  m_tuser;       // [1:0] status
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ffba_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard arena_sb;
  int idle_cycles = 0;
  bit random_stalls = 1'b1;

  always #2 clk_i = ~clk_i;

  first_fit_block_allocator uut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(10, 60);
  endfunction

  // Stall the result side at random; hold ready high during calm stretches.
  always @(posedge clk_i) begin
    if (random_stalls) m_tready <= ($urandom_range(0, 9) < 7);
    else m_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (m_tvalid && m_tready) arena_sb.check_result(m_tdata, m_tuser);
  end

  // Watchdog: count cycles in which no handshake of any kind happens.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one item; keep tvalid high when the next item follows with no gap.
  task automatic send_item(logic op, logic [15:0] req, logic [31:0] addr);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {addr, req};
    do @(posedge clk_i); while (!s_tready);
    arena_sb.note_item(op, req, addr);
    gap = random_stalls ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Lower tvalid, then wait until all results are in and the block has settled.
  task automatic drain();
    @(posedge clk_i);
    s_tvalid <= 1'b0;
    while (arena_sb.due.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle; the write lands at the access edge.
  task automatic write_reg(logic idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    arena_sb.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    repeat (3) @(posedge clk_i);
  endtask

  // Random traffic: mostly small allocates and frees of live blocks, some noise.
  task automatic random_phase(int count, int max_req);
    int pick;
    logic [31:0] addr;
    for (int n = 0; n < count; n++) begin
      random_stalls = ((n / 100) % 3) != 2;
      pick = $urandom_range(0, 99);
      if (pick < ((arena_sb.live.size() > 40) ? 40 : 62)) begin
        if ($urandom_range(0, 19) == 0) send_item(ffba_pkg::OP_ALLOC, 16'($urandom()), '0);
        else send_item(ffba_pkg::OP_ALLOC, 16'($urandom_range(0, max_req)), 32'($urandom()));
      end else begin
        addr = $urandom();
        if (pick < 90 && arena_sb.live.size() != 0)
          addr = arena_sb.live[$urandom_range(0, arena_sb.live.size() - 1)];
        else if (pick < 94 && arena_sb.retired.size() != 0)
          addr = arena_sb.retired[$urandom_range(0, arena_sb.retired.size() - 1)];
        else if (pick < 96)
          addr = '0;
        send_item(ffba_pkg::OP_FREE, 16'($urandom()), addr);
      end
    end
    drain();
  endtask

  initial begin
    arena_sb = new();
    arena_sb.reset_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);

    // Directed: smallest and largest requests, null and unknown frees, double free.
    send_item(ffba_pkg::OP_ALLOC, 16'd0, '0);
    send_item(ffba_pkg::OP_ALLOC, 16'hFFFF, '1);
    send_item(ffba_pkg::OP_FREE, 16'd0, 32'd0);
    send_item(ffba_pkg::OP_FREE, 16'd0, 32'h1234_5679);
    send_item(ffba_pkg::OP_FREE, 16'hFFFF, 32'd32);
    send_item(ffba_pkg::OP_FREE, 16'd0, 32'd32);
    send_item(ffba_pkg::OP_ALLOC, 16'd100, '0);
    send_item(ffba_pkg::OP_ALLOC, 16'd200, '0);
    send_item(ffba_pkg::OP_FREE, 16'd0, 32'd32);
    send_item(ffba_pkg::OP_FREE, 16'd0, 32'd164);
    drain();

    // Granted address wraps to zero.
    write_reg(ffba_pkg::REG_BASE, 32'hFFFF_FFE0);
    send_item(ffba_pkg::OP_ALLOC, 16'd5, '0);
    send_item(ffba_pkg::OP_ALLOC, 16'd5, '0);
    drain();

    // Tiny arena: payload of zero, nothing fits.
    write_reg(ffba_pkg::REG_BASE, 32'd0);
    write_reg(ffba_pkg::REG_BYTES, 32'd20);
    send_item(ffba_pkg::OP_ALLOC, 16'd0, '0);
    drain();

    // Smallest arena: exact whole-block fit.
    write_reg(ffba_pkg::REG_BYTES, 32'd64);
    send_item(ffba_pkg::OP_ALLOC, 16'd1, '0);
    send_item(ffba_pkg::OP_ALLOC, 16'd0, '0);
    send_item(ffba_pkg::OP_ALLOC, 16'd0, '0);
    send_item(ffba_pkg::OP_FREE, 16'd0, 32'd32);
    drain();

    // Exhaust the record pool, then random traffic on the full arena.
    write_reg(ffba_pkg::REG_BASE, $urandom());
    write_reg(ffba_pkg::REG_BYTES, 32'hFFFF);
    for (int n = 0; n < 70; n++)
      send_item(ffba_pkg::OP_ALLOC, 16'($urandom_range(0, 64)), '0);
    random_phase(380, 600);

    write_reg(ffba_pkg::REG_BASE, 32'hFFFF_FFFF);
    write_reg(ffba_pkg::REG_BYTES, 32'd64);
    random_phase(150, 40);

    write_reg(ffba_pkg::REG_BASE, 32'h0000_1000);
    write_reg(ffba_pkg::REG_BYTES, $urandom_range(256, 4096));
    random_phase(500, 200);

    write_reg(ffba_pkg::REG_BASE, $urandom());
    write_reg(ffba_pkg::REG_BYTES, $urandom_range(64, 65535));
    random_phase(580, 2000);

    if (arena_sb.due.size() != 0) begin
      $error("%0d expected results never arrived", arena_sb.due.size());
      arena_sb.errors++;
    end
    if (arena_sb.errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule

// File: first_fit_block_allocator.f
design/ffba_pkg.sv
design/ffba_ram.sv
design/first_fit_block_allocator.sv
dv/tb.sv
